// ===== rtl/core/rrts_pkg.sv =====
// Shared types and codes for the round-robin task scheduler.
// Used by the sequencer, the slot cells and the top level; depends on nothing.
package rrts_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SLEEP = 2'd1;
  localparam logic [1:0] REQ_EXIT  = 2'd2;
  localparam logic [1:0] REQ_FORK  = 2'd3;

  localparam logic [15:0] TIME_SLICE_RESET = 16'd10;
  localparam int          REG_TIME_SLICE   = 0;

  typedef enum logic [1:0] {
    SLOT_DEAD     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2,
    SLOT_BLOCKED  = 2'd3
  } slot_st_t;

  typedef struct packed {
    slot_st_t    st;
    logic [31:0] sleep;
    logic [15:0] slice;
  } slot_rec_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_PASS1 = 2'd1,
    S_PASS2 = 2'd2,
    S_DONE  = 2'd3
  } sched_state_t;

endpackage

// ===== rtl/core/rrts_cell.sv =====
// One slot cell of the scheduler ring: holds a slot record and takes its
// neighbor's record on every shift. Depends on rrts_pkg.
module rrts_cell #(
  parameter bit IDLE_SLOT = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  rrts_pkg::slot_rec_t d,
  output rrts_pkg::slot_rec_t q
);
  import rrts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.st    <= IDLE_SLOT ? SLOT_RUNNING : SLOT_DEAD;
      q.sleep <= '0;
      q.slice <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/core/rrts_seq.sv =====
// Scheduler sequencer: request handshake, head-of-ring slot update, scan
// bookkeeping and the result register. Depends on rrts_pkg.
module rrts_seq #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          s_tuser,
  input  logic [31:0]         s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,
  input  logic [15:0]         time_slice,
  input  rrts_pkg::slot_rec_t head,
  output rrts_pkg::slot_rec_t tail,
  output logic                shift
);
  import rrts_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);

  sched_state_t st, st_next;
  logic [IW-1:0] cnt, cur, hi, lo, fork_idx, nxt, new_cur;
  logic          hi_found, lo_found, fork_done, sw, sw_cur;
  logic [1:0]    req;
  logic [31:0]   ticks;
  logic          cnt_last, cur_hit, cand, take_fork, out_free, load_out;
  logic [IW+3:0] run_wide, fork_wide;
  slot_rec_t     p;

  assign cnt_last = (cnt == IW'(NUM_SLOTS - 1));
  assign cur_hit  = (cnt == cur);
  assign out_free = !m_tvalid || m_tready;
  assign nxt      = hi_found ? hi : lo;

  always_comb begin
    if (req == REQ_FORK) begin
      new_cur = cur;
    end else if (req == REQ_TICK) begin
      new_cur = (sw && (hi_found || lo_found)) ? nxt : cur;
    end else begin
      new_cur = (hi_found || lo_found) ? nxt : '0;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:  if (s_tvalid) st_next = S_PASS1;
      S_PASS1: if (cnt_last) st_next = S_PASS2;
      S_PASS2: if (cnt_last) st_next = S_DONE;
      S_DONE:  if (out_free) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    shift    = 1'b0;
    load_out = 1'b0;
    unique case (st)
      S_IDLE:  s_tready = 1'b1;
      S_PASS1: shift = 1'b1;
      S_PASS2: shift = 1'b1;
      S_DONE:  load_out = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  always_comb begin
    p         = head;
    cand      = 1'b0;
    take_fork = 1'b0;
    sw_cur    = sw;
    if (st == S_PASS1) begin
      unique case (req)
        REQ_TICK: begin
          if (p.st == SLOT_BLOCKED) begin
            if (p.sleep != 32'd0) p.sleep = p.sleep - 32'd1;
            if (p.sleep == 32'd0) p.st = SLOT_RUNNABLE;
          end
          if (cur_hit) begin
            if (p.st == SLOT_RUNNING && p.slice < time_slice) begin
              p.slice = p.slice + 16'd1;
              sw_cur  = 1'b0;
            end else begin
              p.slice = '0;
              p.st    = SLOT_RUNNABLE;
              sw_cur  = 1'b1;
            end
          end
        end
        REQ_SLEEP: begin
          if (cur_hit) begin
            p.sleep = ticks;
            p.st    = SLOT_BLOCKED;
          end
        end
        REQ_EXIT: begin
          if (cur_hit) p.st = SLOT_DEAD;
        end
        REQ_FORK: begin
          if (!fork_done && p.st == SLOT_DEAD) begin
            take_fork = 1'b1;
            p.st      = SLOT_RUNNABLE;
            p.sleep   = '0;
            p.slice   = '0;
          end
        end
        default: p = head;
      endcase
      cand = (p.st == SLOT_RUNNABLE) && (cnt != '0) && !cur_hit;
    end else if (st == S_PASS2) begin
      if (sw && cnt == new_cur) p.st = SLOT_RUNNING;
    end
  end

  assign tail = p;

  assign run_wide  = {4'b0, new_cur};
  assign fork_wide = {4'b0, fork_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      cnt       <= '0;
      cur       <= '0;
      sw        <= 1'b0;
      hi_found  <= 1'b0;
      lo_found  <= 1'b0;
      fork_done <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      st <= st_next;
      if (s_tvalid && s_tready) begin
        req       <= s_tuser;
        ticks     <= s_tdata;
        sw        <= (s_tuser == REQ_SLEEP) || (s_tuser == REQ_EXIT);
        hi_found  <= 1'b0;
        lo_found  <= 1'b0;
        fork_done <= 1'b0;
        fork_idx  <= '0;
        cnt       <= '0;
      end
      if (shift) cnt <= cnt_last ? '0 : cnt + 1'b1;
      if (st == S_PASS1) begin
        if (cur_hit && req == REQ_TICK) sw <= sw_cur;
        if (cand && cnt > cur && !hi_found) begin
          hi       <= cnt;
          hi_found <= 1'b1;
        end
        if (cand && cnt < cur && !lo_found) begin
          lo       <= cnt;
          lo_found <= 1'b1;
        end
        if (take_fork) begin
          fork_done <= 1'b1;
          fork_idx  <= cnt;
        end
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (load_out) begin
        cur      <= new_cur;
        m_tvalid <= 1'b1;
        m_tdata  <= {6'b0, (req == REQ_FORK) && !fork_done, fork_wide[3:0], sw,
                     run_wide[3:0]};
      end
    end
  end

endmodule

// ===== rtl/core/round_robin_task_scheduler.sv =====
// Round-robin task scheduler top level: a ring of NUM_SLOTS slot cells that
// rotates past one head update unit, plus the time slice register.
// An accepted request passes through two full ring rotations (update and scan,
// then marking the chosen slot) and a load of the result once the output is free.
// One item is in work at a time: no new request is accepted until the result is
// loaded. Synchronous reset leaves slot 0 running, all others dead, counters
// zero and time_slice at 10; the block is ready at once.
module round_robin_task_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  input  logic [31:0] s_tdata,   // [31:0] sleep_ticks
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] running_slot, [4] switched,
                                 // [8:5] fork_slot, [9] fork_failed, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrts_pkg::*;

  logic [15:0] time_slice;
  logic        shift;
  slot_rec_t   tail;
  slot_rec_t   ring_q [NUM_SLOTS];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= TIME_SLICE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == 1'(REG_TIME_SLICE)) begin
      time_slice <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == 1'(REG_TIME_SLICE)) ? {16'b0, time_slice} : 32'b0;

  rrts_seq #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .time_slice(time_slice),
    .head      (ring_q[0]),
    .tail      (tail),
    .shift     (shift)
  );

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    if (k == NUM_SLOTS - 1) begin : g_last
      rrts_cell #(
        .IDLE_SLOT(k == 0)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d    (tail),
        .q    (ring_q[k])
      );
    end else begin : g_mid
      rrts_cell #(
        .IDLE_SLOT(k == 0)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d    (ring_q[k+1]),
        .q    (ring_q[k])
      );
    end
  end

endmodule

// ===== rtl/core/rrts_checker.sv =====
// Port-level checks for the round-robin task scheduler, bound to the top
// level. Depends only on the top level's ports.
module rrts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Only one item is in work, so an accept closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A failed fork never reschedules and reports no slot.
  a_fork_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> !m_tdata[4] && m_tdata[8:5] == 4'd0)
    else $error("failed fork reported a slot or a switch");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:10] == 6'd0)
    else $error("padding bits of result not zero");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
